@@ hw/rtl/utl_pkg.sv @@
// Shared types and constants for the 8N1 tick link.
// Used by utl_stage, utl_core and uart_8n1_tick_link; no other dependencies.
package utl_pkg;

  localparam int unsigned InWidth  = 16;
  localparam int unsigned OutWidth = 16;

  localparam logic [7:0]  EofByte        = 8'h1A;
  localparam logic [15:0] BitPeriodReset = 16'd512;
  localparam logic [4:0]  FrameSlots     = 5'd11;
  localparam logic [3:0]  CapStopSlot    = 4'd9;
  localparam logic [3:0]  CapLastData    = 4'd8;
  localparam logic [3:0]  SendLastData   = 4'd8;
  localparam logic [3:0]  SendLastSlot   = 4'd10;

  // Input word, packed from bit 0 upward: start_save first.
  typedef struct packed {
    logic [2:0] pad;
    logic       next_byte_valid;
    logic [7:0] next_byte;
    logic       sample_bit;
    logic       sample_strobe;
    logic       start_load;
    logic       start_save;
  } in_item_t;

  // Result word, packed from bit 0 upward: line_level first.
  typedef struct packed {
    logic       pad;
    logic       load_refused;
    logic       save_refused;
    logic       send_ended;
    logic       byte_taken;
    logic       capture_ended;
    logic       byte_out_valid;
    logic [7:0] byte_out;
    logic       line_level;
  } out_item_t;

endpackage

@@ hw/rtl/uart_8n1_tick_link.sv @@
// Top level of the 8N1 tick link: input slice, link core and result slice.
// Depends on utl_pkg, utl_stage and utl_core.
//
// Each input word is one machine tick and yields exactly one result word. The
// block accepts a word every cycle while the result side is not stalled; a
// result passes through the input register and then the result register, and
// the whole tick update is done combinationally between them. The bit
// period register may be written only while no word is in flight.
module uart_8n1_tick_link (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_save, start_load, sample_strobe, sample_bit, next_byte[7:0],
  // next_byte_valid, zero pad
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // line_level, byte_out[7:0], byte_out_valid, capture_ended, byte_taken,
  // send_ended, save_refused, load_refused, zero pad
  output logic [15:0] m_axis_tdata
);

  logic [15:0]        period_q;
  logic               in_valid;
  logic               res_ready;
  logic               advance;
  utl_pkg::in_item_t  in_item;
  utl_pkg::out_item_t res_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= utl_pkg::BitPeriodReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  utl_stage #(
    .Width(utl_pkg::InWidth)
  ) u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (s_axis_tvalid),
    .up_ready_o (s_axis_tready),
    .up_data_i  (s_axis_tdata),
    .dn_valid_o (in_valid),
    .dn_ready_i (res_ready),
    .dn_data_o  (in_item)
  );

  assign advance = in_valid && res_ready;

  utl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .period_i (period_q),
    .item_i   (in_item),
    .res_o    (res_item)
  );

  utl_stage #(
    .Width(utl_pkg::OutWidth)
  ) u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid),
    .up_ready_o (res_ready),
    .up_data_i  (res_item),
    .dn_valid_o (m_axis_tvalid),
    .dn_ready_i (m_axis_tready),
    .dn_data_o  (m_axis_tdata)
  );

endmodule

@@ hw/rtl/utl_stage.sv @@
// One-entry register slice with a valid/ready handshake on both sides.
// Depends on utl_pkg only for the default width; the instantiating module sets it.
module utl_stage #(
  parameter int unsigned Width = utl_pkg::InWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  logic [Width-1:0] up_data_i,
  output logic             dn_valid_o,
  input  logic             dn_ready_i,
  output logic [Width-1:0] dn_data_o
);

  logic             valid_q, valid_d;
  logic [Width-1:0] data_q;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign valid_d    = up_ready_o ? up_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= up_data_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

@@ hw/rtl/utl_core.sv @@
// Capture and send state of the 8N1 link, stepped once per enabled tick.
// Depends on utl_pkg for the word types and frame constants.
module utl_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [15:0]         period_i,
  input  utl_pkg::in_item_t   item_i,
  output utl_pkg::out_item_t  res_o
);

  logic        cap_active_q, cap_active_d;
  logic [3:0]  cap_slot_q, cap_slot_d;
  logic [7:0]  cap_shift_q, cap_shift_d;
  logic        snd_active_q, snd_active_d;
  logic [3:0]  snd_slot_q, snd_slot_d;
  logic        snd_first_q, snd_first_d;
  logic [7:0]  snd_byte_q, snd_byte_d;
  logic        dry_q, dry_d;
  logic [15:0] timer_q, timer_d;
  logic        line_q, line_d;

  logic [16:0] timer_next;
  logic [4:0]  slot_inc;
  logic [2:0]  cap_idx;
  logic [2:0]  snd_idx;

  always_comb begin
    cap_active_d = cap_active_q;
    cap_slot_d   = cap_slot_q;
    cap_shift_d  = cap_shift_q;
    snd_active_d = snd_active_q;
    snd_slot_d   = snd_slot_q;
    snd_first_d  = snd_first_q;
    snd_byte_d   = snd_byte_q;
    dry_d        = dry_q;
    timer_d      = timer_q;
    line_d       = line_q;
    res_o        = '0;
    timer_next   = {1'b0, timer_q} + 17'd1;
    slot_inc     = {1'b0, snd_slot_q} + 5'd1;
    cap_idx      = cap_slot_q[2:0] - 3'd1;
    snd_idx      = snd_slot_q[2:0] - 3'd1;

    if (item_i.start_save) begin
      if (cap_active_q) begin
        res_o.save_refused = 1'b1;
      end else begin
        cap_active_d = 1'b1;
      end
    end
    if (item_i.start_load) begin
      if (snd_active_q) begin
        res_o.load_refused = 1'b1;
      end else begin
        snd_active_d = 1'b1;
        dry_d        = 1'b0;
      end
    end

    if (cap_active_d && item_i.sample_strobe) begin
      if (cap_slot_q == 4'd0) begin
        if (!item_i.sample_bit) begin
          cap_shift_d = '0;
          cap_slot_d  = 4'd1;
        end
      end else if (cap_slot_q <= utl_pkg::CapLastData) begin
        cap_shift_d[cap_idx] = cap_shift_q[cap_idx] | item_i.sample_bit;
        cap_slot_d           = cap_slot_q + 4'd1;
      end else if (cap_slot_q == utl_pkg::CapStopSlot) begin
        if (cap_shift_q == utl_pkg::EofByte) begin
          cap_active_d        = 1'b0;
          res_o.capture_ended = 1'b1;
        end else begin
          res_o.byte_out       = cap_shift_q;
          res_o.byte_out_valid = 1'b1;
        end
        cap_slot_d = 4'd0;
      end else begin
        cap_slot_d = 4'd0;
      end
    end

    if (!snd_active_d) begin
      timer_d = period_i;
    end else if (timer_next > {1'b0, period_i}) begin
      timer_d = '0;
      if (!snd_first_q) begin
        line_d      = 1'b1;
        snd_first_d = 1'b1;
      end else begin
        if (snd_slot_q == 4'd0) begin
          if (item_i.next_byte_valid) begin
            snd_byte_d       = item_i.next_byte;
            res_o.byte_taken = 1'b1;
          end else begin
            snd_byte_d = utl_pkg::EofByte;
            dry_d      = 1'b1;
          end
          line_d = 1'b0;
        end else if (snd_slot_q <= utl_pkg::SendLastData) begin
          line_d = snd_byte_q[snd_idx];
        end else begin
          line_d = 1'b1;
        end
        snd_slot_d = slot_inc[3:0];
        if (slot_inc >= utl_pkg::FrameSlots) begin
          snd_slot_d = 4'd0;
          if (dry_d) begin
            snd_active_d     = 1'b0;
            res_o.send_ended = 1'b1;
          end
        end
      end
    end else begin
      timer_d = timer_next[15:0];
    end

    res_o.line_level = line_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_active_q <= 1'b0;
      cap_slot_q   <= 4'd0;
      cap_shift_q  <= 8'd0;
      snd_active_q <= 1'b0;
      snd_slot_q   <= 4'd0;
      snd_first_q  <= 1'b0;
      snd_byte_q   <= 8'd0;
      dry_q        <= 1'b0;
      timer_q      <= 16'd0;
      line_q       <= 1'b1;
    end else if (en_i) begin
      cap_active_q <= cap_active_d;
      cap_slot_q   <= cap_slot_d;
      cap_shift_q  <= cap_shift_d;
      snd_active_q <= snd_active_d;
      snd_slot_q   <= snd_slot_d;
      snd_first_q  <= snd_first_d;
      snd_byte_q   <= snd_byte_d;
      dry_q        <= dry_d;
      timer_q      <= timer_d;
      line_q       <= line_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_slot_q <= utl_pkg::CapStopSlot)
    else $error("capture slot left its range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    snd_slot_q <= utl_pkg::SendLastSlot)
    else $error("send slot left its range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |-> !(res_o.byte_out_valid && res_o.capture_ended))
    else $error("byte emitted on the closing stop slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.send_ended |=> !snd_active_q)
    else $error("sending still active after the final frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.byte_taken |-> item_i.next_byte_valid && snd_slot_q == 4'd0)
    else $error("source byte taken outside a valid start slot");
`endif

endmodule
